FILE: sv/rnas_pkg.sv
package rnas_pkg;

    localparam int N_INPUTS_DEF  = 12;
    localparam int N_HIDDEN_DEF  = 4;
    localparam int N_OUTPUTS_DEF = 4;
    localparam int NUM_CHOICES   = 4;
    localparam logic signed [15:0] ONE_Q88 = 16'sd256;

    localparam logic [1:0] ACT_WR_WEIGHT = 2'd0;
    localparam logic [1:0] ACT_WR_INPUT  = 2'd1;
    localparam logic [1:0] ACT_EVALUATE  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_COMMIT,
        ST_REPORT
    } t_state;

    // Row-sum accumulator round and saturate: floor((acc + 128) / 256) clamped.
    function automatic logic signed [15:0] round_sat(input logic signed [47:0] acc);
        logic signed [47:0] x;
        logic signed [39:0] q;
        x = acc + 48'sd128;
        q = x[47:8];
        if (q > 40'sd32767)       round_sat = 16'sd32767;
        else if (q < -40'sd32768) round_sat = -16'sd32768;
        else                      round_sat = q[15:0];
    endfunction

    function automatic logic [8:0] tanh_tab(input logic [5:0] k);
        logic [8:0] t;
        unique case (k)
            6'd0: t = 9'd0;     6'd1: t = 9'd32;    6'd2: t = 9'd63;
            6'd3: t = 9'd92;    6'd4: t = 9'd118;   6'd5: t = 9'd142;
            6'd6: t = 9'd163;   6'd7: t = 9'd180;   6'd8: t = 9'd195;
            6'd9: t = 9'd207;   6'd10: t = 9'd217;  6'd11: t = 9'd225;
            6'd12: t = 9'd232;  6'd13: t = 9'd237;  6'd14: t = 9'd241;
            6'd15: t = 9'd244;  6'd16: t = 9'd247;  6'd17: t = 9'd249;
            6'd18: t = 9'd250;  6'd19: t = 9'd252;  6'd20: t = 9'd253;
            6'd21: t = 9'd253;  6'd22: t = 9'd254;  6'd23: t = 9'd254;
            6'd24: t = 9'd255;  6'd25: t = 9'd255;  6'd26: t = 9'd255;
            6'd27: t = 9'd255;
            default: t = 9'd256;
        endcase
        tanh_tab = t;
    endfunction

    function automatic logic signed [15:0] tanh_q88(input logic signed [15:0] v);
        logic [16:0] a;
        logic [4:0]  i;
        logic [4:0]  f;
        logic signed [10:0] d;
        logic signed [16:0] p;
        logic [8:0]  r;
        a = v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
        i = a[9:5];
        f = a[4:0];
        d = $signed({2'b00, tanh_tab({1'b0, i} + 6'd1)}) - $signed({2'b00, tanh_tab({1'b0, i})});
        p = (d * $signed({12'd0, f})) + 17'sd16;
        if (a >= 17'd1024) r = 9'd256;
        else r = tanh_tab({1'b0, i}) + 9'(p >>> 5);
        tanh_q88 = v[15] ? -$signed({7'd0, r}) : $signed({7'd0, r});
    endfunction

endpackage

FILE: sv/rnas_cell.sv
// One row of the net: holds its weights, accumulates as neurons stream past,
// and passes each neuron on to the next row.
module rnas_cell #(
    parameter int NUM_COLS = 16,
    parameter int IDX_W    = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_w_we,
    input  logic [IDX_W-1:0]        i_w_col,
    input  logic signed [15:0]      i_w_val,
    input  logic                    i_clr,
    input  logic                    i_nv,
    input  logic [IDX_W-1:0]        i_ncol,
    input  logic signed [15:0]      i_nval,
    output logic                    o_nv,
    output logic [IDX_W-1:0]        o_ncol,
    output logic signed [15:0]      o_nval,
    output logic signed [47:0]      o_acc
);
    import rnas_pkg::*;

    logic signed [15:0] r_w [NUM_COLS];
    logic signed [47:0] r_acc;
    logic               r_nv;
    logic [IDX_W-1:0]   r_ncol;
    logic signed [15:0] r_nval;
    logic signed [31:0] w_prod;

    assign w_prod = r_w[i_ncol] * i_nval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COLS; k++) r_w[k] <= '0;
            r_nv <= 1'b0;
        end else begin
            if (i_w_we) r_w[i_w_col] <= i_w_val;
            r_nv <= i_nv;
        end
        r_ncol <= i_ncol;
        r_nval <= i_nval;
        if (i_clr) r_acc <= '0;
        else if (i_nv) r_acc <= r_acc + 48'(w_prod);
    end

    assign o_nv   = r_nv;
    assign o_ncol = r_ncol;
    assign o_nval = r_nval;
    assign o_acc  = r_acc;
endmodule

FILE: sv/recurrent_net_action_selector_core.sv
// Channel   | Direction | Ports
// ----------+-----------+-----------------------------------------------
// command   | in        | i_start, o_busy, i_action, i_index, i_value
// result    | out       | o_valid, o_chosen_action, o_*_level
// config    | in        | i_cfg_we, i_cfg_data (iteration_count)
//
// An evaluation holds o_busy while its passes run and the result strobe
// follows in the next cycle: each pass streams the input and hidden neurons
// once down the row of cells, drains, then commits.
// Synchronous active-low reset clears weights, neurons and control.
// Results show for one cycle with o_valid; the receiver cannot stall.
module recurrent_net_action_selector_core #(
    parameter int N_INPUTS  = rnas_pkg::N_INPUTS_DEF,
    parameter int N_HIDDEN  = rnas_pkg::N_HIDDEN_DEF,
    parameter int N_OUTPUTS = rnas_pkg::N_OUTPUTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_action,
    input  logic [7:0]         i_index,
    input  logic signed [15:0] i_value,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_data,
    output logic               o_valid,
    output logic [2:0]         o_chosen_action,
    output logic signed [15:0] o_forward_level,
    output logic signed [15:0] o_left_level,
    output logic signed [15:0] o_right_level,
    output logic signed [15:0] o_reproduce_level
);
    import rnas_pkg::*;

    localparam int NUM_ROWS    = N_HIDDEN + N_OUTPUTS;
    localparam int N_NEURONS   = N_INPUTS + NUM_ROWS;
    localparam int NUM_COLS    = N_INPUTS + N_HIDDEN;
    localparam int NUM_WEIGHTS = NUM_ROWS * N_NEURONS;
    localparam int IDX_W       = $clog2(NUM_COLS);
    localparam int NEU_W       = $clog2(N_NEURONS);
    localparam int CNT_W       = $clog2(NUM_COLS + NUM_ROWS + 2);
    localparam int DRAIN       = NUM_COLS + NUM_ROWS;

    t_state r_state, n_state;
    logic [3:0]  r_iters;
    logic [3:0]  r_pass;
    logic [CNT_W-1:0] r_cnt;
    logic signed [15:0] r_neu [N_NEURONS];

    logic [7:0] w_row;
    logic [7:0] w_col;
    logic       w_we_ok;

    always_comb begin
        w_row = '0;
        w_col = i_index;
        for (int r = 1; r < NUM_ROWS; r++)
            if (i_index >= 8'(r * N_NEURONS)) begin
                w_row = 8'(r);
                w_col = i_index - 8'(r * N_NEURONS);
            end
        w_we_ok = i_start && !o_busy && i_action == ACT_WR_WEIGHT
                  && i_index < 8'(NUM_WEIGHTS) && w_col < 8'(NUM_COLS);
    end

    logic               c_nv   [NUM_ROWS+1];
    logic [IDX_W-1:0]   c_ncol [NUM_ROWS+1];
    logic signed [15:0] c_nval [NUM_ROWS+1];
    logic signed [47:0] c_acc  [NUM_ROWS];

    logic w_feed;
    assign w_feed    = r_state == ST_MAC && r_cnt < CNT_W'(NUM_COLS);
    assign c_nv[0]   = w_feed;
    assign c_ncol[0] = IDX_W'(r_cnt);
    assign c_nval[0] = r_neu[w_feed ? NEU_W'(r_cnt) : '0];

    for (genvar g = 0; g < NUM_ROWS; g++) begin : g_row
        rnas_cell #(.NUM_COLS(NUM_COLS), .IDX_W(IDX_W)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_w_we (w_we_ok && w_row == 8'(g)),
            .i_w_col(IDX_W'(w_col)),
            .i_w_val(i_value),
            .i_clr  (r_state != ST_MAC),
            .i_nv   (c_nv[g]),
            .i_ncol (c_ncol[g]),
            .i_nval (c_nval[g]),
            .o_nv   (c_nv[g+1]),
            .o_ncol (c_ncol[g+1]),
            .o_nval (c_nval[g+1]),
            .o_acc  (c_acc[g])
        );
    end

    always_comb begin
        n_state = r_state;
        o_busy  = r_state != ST_IDLE;
        unique case (r_state)
            ST_IDLE:
                if (i_start && i_action == ACT_EVALUATE)
                    n_state = (r_iters == 4'd0) ? ST_REPORT : ST_MAC;
            ST_MAC:
                if (r_cnt == CNT_W'(DRAIN)) n_state = ST_COMMIT;
            ST_COMMIT:
                n_state = (r_pass + 4'd1 >= r_iters) ? ST_REPORT : ST_MAC;
            ST_REPORT:
                n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_iters <= 4'd1;
            r_pass  <= '0;
            r_cnt   <= '0;
            for (int k = 0; k < N_NEURONS; k++) r_neu[k] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_iters <= i_cfg_data;
            if (r_state == ST_IDLE) begin
                r_pass <= '0;
                r_cnt  <= '0;
                if (i_start && i_action == ACT_WR_INPUT && i_index < 8'(N_INPUTS))
                    r_neu[NEU_W'(i_index)] <= i_value;
            end else if (r_state == ST_MAC) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (r_state == ST_COMMIT) begin
                r_cnt  <= '0;
                r_pass <= r_pass + 4'd1;
                for (int j = 0; j < NUM_ROWS; j++)
                    r_neu[N_INPUTS+j] <= (j < N_HIDDEN)
                        ? tanh_q88(round_sat(c_acc[j])) : round_sat(c_acc[j]);
            end
        end
    end

    // Accumulators are cleared in idle; restart each pass via the commit state.
    logic signed [15:0] w_lvl [NUM_CHOICES];
    logic [2:0] w_choice;
    logic signed [15:0] w_best;
    always_comb begin
        w_choice = '0;
        w_best   = ONE_Q88;
        for (int j = 0; j < NUM_CHOICES; j++) begin
            w_lvl[j] = (j < N_OUTPUTS) ? r_neu[(j < N_OUTPUTS) ? NUM_COLS + j : 0] : '0;
            if (j < N_OUTPUTS && w_lvl[j] >= w_best) begin
                w_best   = w_lvl[j];
                w_choice = 3'(j + 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_state == ST_REPORT;
        o_chosen_action   <= w_choice;
        o_forward_level   <= w_lvl[0];
        o_left_level      <= w_lvl[1];
        o_right_level     <= w_lvl[2];
        o_reproduce_level <= w_lvl[3];
    end
endmodule
